// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, held off while reset is asserted
`define TDE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tde: assertion failed");

// Checked property that also holds through reset
`define TDE_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tde: assertion failed in reset");

`endif

// ===== hdl/tde_pkg.sv =====
// Shared types, constants and the fixed codebook for the trace delta encoder.
// Depends on nothing.
package tde_pkg;

    localparam int MAX_ZERO_RUN_DEF    = 126;
    localparam int LOOKAHEAD_DEPTH_DEF = 5;
    localparam int TOP_CODE_INDEX_DEF  = 124;

    localparam int BOOK_SIZE  = 125;
    localparam int WORD_W     = 7;
    localparam int WORD_MAX   = 5;
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = 5;

    localparam logic [7:0] BYTE_SMALL = 8'h80 | 8'd126;
    localparam logic [7:0] BYTE_BIG   = 8'h80 | 8'd127;

    typedef enum logic [3:0] {
        ST_IDLE, ST_HEAD, ST_SCAN, ST_DRAIN, ST_SMALL, ST_BIG_HI, ST_BIG_LO, ST_FLUSH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_HEAD, OP_SCAN, OP_DRAIN, OP_SMALL, OP_BIG_HI, OP_BIG_LO,
        OP_FLUSH
    } dp_op_t;

    typedef enum logic [1:0] {
        DK_DONE, DK_NEXT, DK_SMALL, DK_BIG
    } drain_kind_t;

    typedef struct packed {
        logic        can_emit;
        logic        head_scan;
        drain_kind_t drain_kind;
    } dp_status_t;

    typedef int book_row_t [6];

    // length, then up to five word values
    localparam book_row_t BOOK [BOOK_SIZE] = '{
        '{0,0,0,0,0,0},
        '{1,1,0,0,0,0},'{1,-1,0,0,0,0},'{1,2,0,0,0,0},'{1,-2,0,0,0,0},
        '{1,3,0,0,0,0},'{1,-3,0,0,0,0},'{1,4,0,0,0,0},'{1,-4,0,0,0,0},
        '{1,5,0,0,0,0},'{1,-5,0,0,0,0},'{1,6,0,0,0,0},'{1,-6,0,0,0,0},
        '{1,7,0,0,0,0},'{1,-7,0,0,0,0},'{1,8,0,0,0,0},'{1,-8,0,0,0,0},
        '{1,9,0,0,0,0},'{1,-9,0,0,0,0},'{1,10,0,0,0,0},'{1,-10,0,0,0,0},
        '{1,11,0,0,0,0},'{1,-11,0,0,0,0},
        '{2,1,0,0,0,0},'{2,-1,0,0,0,0},'{2,2,0,0,0,0},'{2,-2,0,0,0,0},
        '{2,3,0,0,0,0},'{2,-3,0,0,0,0},'{2,4,0,0,0,0},'{2,-4,0,0,0,0},
        '{2,5,0,0,0,0},'{2,-5,0,0,0,0},
        '{2,1,1,0,0,0},'{2,-1,1,0,0,0},'{2,2,1,0,0,0},'{2,-2,1,0,0,0},
        '{2,3,1,0,0,0},'{2,-3,1,0,0,0},'{2,4,1,0,0,0},'{2,-4,1,0,0,0},
        '{2,5,1,0,0,0},'{2,-5,1,0,0,0},
        '{2,1,-1,0,0,0},'{2,-1,-1,0,0,0},'{2,2,-1,0,0,0},'{2,-2,-1,0,0,0},
        '{2,3,-1,0,0,0},'{2,-3,-1,0,0,0},'{2,4,-1,0,0,0},'{2,-4,-1,0,0,0},
        '{2,5,-1,0,0,0},'{2,-5,-1,0,0,0},
        '{2,1,1,0,0,0},'{2,1,-1,0,0,0},'{2,1,2,0,0,0},'{2,1,-2,0,0,0},
        '{2,1,3,0,0,0},'{2,1,-3,0,0,0},'{2,1,4,0,0,0},'{2,1,-4,0,0,0},
        '{2,1,5,0,0,0},'{2,1,-5,0,0,0},
        '{2,-1,1,0,0,0},'{2,-1,-1,0,0,0},'{2,-1,2,0,0,0},'{2,-1,-2,0,0,0},
        '{2,-1,3,0,0,0},'{2,-1,-3,0,0,0},'{2,-1,4,0,0,0},'{2,-1,-4,0,0,0},
        '{2,-1,5,0,0,0},'{2,-1,-5,0,0,0},
        '{3,1,0,1,0,0},'{3,1,0,-1,0,0},'{3,1,1,1,0,0},'{3,1,1,-1,0,0},
        '{3,1,-1,1,0,0},'{3,1,-1,1,0,0},
        '{3,-1,0,1,0,0},'{3,-1,0,-1,0,0},'{3,-1,1,1,0,0},'{3,-1,1,-1,0,0},
        '{3,-1,-1,1,0,0},'{3,-1,-1,1,0,0},
        '{4,1,0,0,1,0},'{4,1,0,1,1,0},'{4,1,0,-1,1,0},'{4,1,1,0,1,0},
        '{4,1,1,1,1,0},'{4,1,1,-1,1,0},
        '{4,1,-1,0,1,0},'{4,1,-1,1,1,0},'{4,1,-1,-1,1,0},
        '{4,1,0,0,-1,0},'{4,1,0,1,-1,0},'{4,1,0,-1,-1,0},'{4,1,1,0,-1,0},
        '{4,1,1,1,-1,0},'{4,1,1,-1,-1,0},
        '{4,1,-1,0,-1,0},'{4,1,-1,1,-1,0},'{4,1,-1,-1,-1,0},
        '{4,-1,0,0,1,0},'{4,-1,0,1,1,0},'{4,-1,0,-1,1,0},'{4,-1,1,0,1,0},
        '{4,-1,1,1,1,0},'{4,-1,1,-1,1,0},
        '{4,-1,-1,0,1,0},'{4,-1,-1,1,1,0},'{4,-1,-1,-1,1,0},
        '{4,-1,0,0,-1,0},'{4,-1,0,1,-1,0},'{4,-1,0,-1,-1,0},'{4,-1,1,0,-1,0},
        '{4,-1,1,1,-1,0},'{4,-1,1,-1,-1,0},
        '{4,-1,-1,0,-1,0},'{4,-1,-1,1,-1,0},'{4,-1,-1,-1,-1,0},
        '{5,1,0,0,0,1},'{5,1,0,0,0,-1},'{5,-1,0,0,0,1},'{5,-1,0,0,0,-1}
    };

endpackage

// ===== hdl/tde_ctrl.sv =====
// Sequencer for the trace delta encoder: one token decision per pass.
// Depends on tde_pkg; drives the datapath by op code, reads its status.
module tde_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tde_pkg::dp_status_t status,
    output tde_pkg::dp_op_t     op
);
    import tde_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                if (status.can_emit) begin
                    op         = OP_HEAD;
                    state_next = status.head_scan ? ST_SCAN : ST_FLUSH;
                end
            end
            ST_SCAN: begin
                op         = OP_SCAN;
                state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (status.can_emit) begin
                    op = OP_DRAIN;
                    unique case (status.drain_kind)
                        DK_DONE:  state_next = ST_FLUSH;
                        DK_NEXT:  state_next = ST_SCAN;
                        DK_SMALL: state_next = ST_SMALL;
                        DK_BIG:   state_next = ST_BIG_HI;
                        default:  state_next = ST_FLUSH;
                    endcase
                end
            end
            ST_SMALL: begin
                if (status.can_emit) begin
                    op         = OP_SMALL;
                    state_next = ST_SCAN;
                end
            end
            ST_BIG_HI: begin
                if (status.can_emit) begin
                    op         = OP_BIG_HI;
                    state_next = ST_BIG_LO;
                end
            end
            ST_BIG_LO: begin
                if (status.can_emit) begin
                    op         = OP_BIG_LO;
                    state_next = ST_SCAN;
                end
            end
            ST_FLUSH: begin
                if (status.can_emit) begin
                    op         = OP_FLUSH;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/tde_datapath.sv =====
// Datapath: lookahead window, zero run counter, codebook match, byte output.
// Depends on tde_pkg; executes the op codes from tde_ctrl.
module tde_datapath #(
    parameter int MAX_ZERO_RUN    = tde_pkg::MAX_ZERO_RUN_DEF,
    parameter int LOOKAHEAD_DEPTH = tde_pkg::LOOKAHEAD_DEPTH_DEF,
    parameter int TOP_CODE_INDEX  = tde_pkg::TOP_CODE_INDEX_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tde_pkg::dp_op_t     op,
    output tde_pkg::dp_status_t status,
    input  logic [15:0]         s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);
    import tde_pkg::*;

    localparam int FILL_W = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int IDX_W  = $clog2(LOOKAHEAD_DEPTH);

    logic signed [15:0] win_reg [LOOKAHEAD_DEPTH];
    logic signed [15:0] win_next [LOOKAHEAD_DEPTH];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [6:0]         zrun_reg, zrun_next;
    logic signed [15:0] x_reg;
    logic               last_reg;
    logic [WORD_W-1:0]  word_reg, word_next;

    logic [7:0]       pend_reg;
    logic             pend_vld_reg, pend_vld_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       out_byte_reg;
    logic             out_vld_reg, out_last_reg;
    logic             out_load;

    logic              emit_en, drop_en, flush_en;
    logic [7:0]        emit_byte;
    logic [FILL_W-1:0] drop_k;
    logic [7:0]        zr1;
    logic [FILL_W-1:0] zcnt;
    logic              zscan;
    logic [WORD_W-1:0] word_len;
    logic [4:0]        code [WORD_MAX];
    logic              code_ok [WORD_MAX];
    logic              wmatch;
    logic [15:0]       biased;
    logic              is_small;

    // 5-bit codes of the window head; book values all fit in -16..15
    always_comb begin
        for (int k = 0; k < WORD_MAX; k++) begin
            code[k]    = win_reg[k][4:0];
            code_ok[k] = (win_reg[k][15:4] == {12{win_reg[k][4]}});
        end
    end

    // codebook search; the highest matching number wins
    always_comb begin
        word_next = '0;
        for (int w = 2; w < BOOK_SIZE; w++) begin
            wmatch = (w <= TOP_CODE_INDEX) &&
                     (BOOK[w][0] <= int'(fill_reg));
            for (int k = 0; k < WORD_MAX; k++) begin
                if (k < BOOK[w][0]) begin
                    if (!(code_ok[k] && code[k] == 5'(BOOK[w][k+1]))) begin
                        wmatch = 1'b0;
                    end
                end
            end
            if (wmatch) begin
                word_next = WORD_W'(w);
            end
        end
    end

    // leading zeros in the window, capped at the run limit
    always_comb begin
        zcnt  = '0;
        zscan = 1'b1;
        for (int k = 0; k < LOOKAHEAD_DEPTH; k++) begin
            if (zscan && k < int'(fill_reg) && k < MAX_ZERO_RUN && win_reg[k] == 16'sd0) begin
                zcnt = FILL_W'(k + 1);
            end else begin
                zscan = 1'b0;
            end
        end
    end

    assign word_len = WORD_W'(BOOK[word_reg][0]);
    assign zr1      = {1'b0, zrun_reg} + 8'd1;
    assign biased   = win_reg[0] + 16'sd128;
    assign is_small = (win_reg[0][15:7] == {9{win_reg[0][7]}});

    always_comb begin
        status.can_emit  = !pend_vld_reg || !out_vld_reg || m_tready;
        status.head_scan = !(zrun_reg != '0 && x_reg == 16'sd0);
        if (fill_reg == '0) begin
            status.drain_kind = DK_DONE;
        end else if (win_reg[0] == 16'sd0) begin
            if (zcnt < fill_reg || int'(zcnt) >= MAX_ZERO_RUN || last_reg) begin
                status.drain_kind = DK_NEXT;
            end else begin
                status.drain_kind = DK_DONE;
            end
        end else if (int'(fill_reg) < LOOKAHEAD_DEPTH && !last_reg) begin
            status.drain_kind = DK_DONE;
        end else if (word_reg != '0) begin
            status.drain_kind = DK_NEXT;
        end else if (is_small) begin
            status.drain_kind = DK_SMALL;
        end else begin
            status.drain_kind = DK_BIG;
        end
    end

    // op decode: at most one byte and one drop per op
    always_comb begin
        emit_en   = 1'b0;
        emit_byte = '0;
        drop_en   = 1'b0;
        drop_k    = '0;
        flush_en  = 1'b0;
        zrun_next = zrun_reg;
        for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
            win_next[i] = win_reg[i];
        end
        fill_next = fill_reg;
        unique case (op)
            OP_HEAD: begin
                if (!status.head_scan) begin
                    if (int'(zr1) >= MAX_ZERO_RUN || last_reg) begin
                        emit_en   = 1'b1;
                        emit_byte = {1'b0, zr1[6:0]};
                        zrun_next = '0;
                    end else begin
                        zrun_next = zr1[6:0];
                    end
                end else begin
                    if (zrun_reg != '0) begin
                        emit_en   = 1'b1;
                        emit_byte = {1'b0, zrun_reg};
                    end
                    zrun_next = '0;
                    win_next[fill_reg[IDX_W-1:0]] = x_reg;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            OP_DRAIN: begin
                if (fill_reg == '0) begin
                    // nothing buffered
                end else if (win_reg[0] == 16'sd0) begin
                    if (status.drain_kind == DK_NEXT) begin
                        emit_en   = 1'b1;
                        emit_byte = 8'(zcnt) & 8'h7f;
                        drop_en   = 1'b1;
                        drop_k    = zcnt;
                    end else begin
                        zrun_next = 7'(zcnt);
                        fill_next = '0;
                    end
                end else begin
                    unique case (status.drain_kind)
                        DK_NEXT: begin
                            emit_en   = 1'b1;
                            emit_byte = 8'h80 | {1'b0, word_reg};
                            drop_en   = 1'b1;
                            drop_k    = FILL_W'(word_len);
                        end
                        DK_SMALL: begin
                            emit_en   = 1'b1;
                            emit_byte = BYTE_SMALL;
                        end
                        DK_BIG: begin
                            emit_en   = 1'b1;
                            emit_byte = BYTE_BIG;
                        end
                        default: ;
                    endcase
                end
            end
            OP_SMALL: begin
                emit_en   = 1'b1;
                emit_byte = biased[7:0];
                drop_en   = 1'b1;
                drop_k    = FILL_W'(1);
            end
            OP_BIG_HI: begin
                emit_en   = 1'b1;
                emit_byte = win_reg[0][15:8];
            end
            OP_BIG_LO: begin
                emit_en   = 1'b1;
                emit_byte = win_reg[0][7:0];
                drop_en   = 1'b1;
                drop_k    = FILL_W'(1);
            end
            OP_FLUSH: flush_en = 1'b1;
            default: ;
        endcase
        if (drop_en) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
                if (i + int'(drop_k) < LOOKAHEAD_DEPTH) begin
                    win_next[i] = win_reg[i + int'(drop_k)];
                end
            end
            fill_next = (drop_k >= fill_reg) ? '0 : fill_reg - drop_k;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_LOAD) begin
            x_reg    <= s_tdata;
            last_reg <= s_tlast;
        end
        if (op == OP_SCAN) begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
                win_reg[i] <= '0;
            end
            fill_reg <= '0;
            zrun_reg <= '0;
        end else begin
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
                win_reg[i] <= win_next[i];
            end
            fill_reg <= fill_next;
            zrun_reg <= zrun_next;
        end
    end

    // one byte held back so the block's last byte can be flagged
    always_comb begin
        pend_vld_next = pend_vld_reg;
        if (emit_en && int'(cnt_reg) < RESULT_CAP) begin
            pend_vld_next = 1'b1;
        end else if (flush_en) begin
            pend_vld_next = 1'b0;
        end
    end

    assign out_load = pend_vld_reg &&
                      ((emit_en && int'(cnt_reg) < RESULT_CAP) || flush_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            pend_vld_reg <= pend_vld_next;
            if (out_load) begin
                out_vld_reg  <= 1'b1;
                out_byte_reg <= pend_reg;
                out_last_reg <= flush_en && last_reg;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (emit_en && int'(cnt_reg) < RESULT_CAP) begin
                pend_reg <= emit_byte;
                cnt_reg  <= cnt_reg + CNT_W'(1);
            end else if (flush_en) begin
                cnt_reg <= '0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hdl/trace_delta_codebook_encoder.sv =====
// Trace delta codebook encoder. Takes one signed 16-bit sample per request
// (tlast ends a block) and returns the compressed byte stream, tlast on the
// block's last byte. A sample that only extends a zero run passes through
// the load, head and flush states; any other sample is also buffered, each
// token it settles takes a scan and a decide state, and each extra byte of
// a literal (0xFE or 0xFF forms) has a state of its own. The sequencer
// settles one token per scan/decide pass over the lookahead window (five
// samples by default) and hands bytes to the single output byte register; a
// stalled m_tready holds the sequencer. The block takes no new sample until
// all bytes of the current one have been handed to the output register.
module trace_delta_codebook_encoder #(
    parameter int MAX_ZERO_RUN    = tde_pkg::MAX_ZERO_RUN_DEF,
    parameter int LOOKAHEAD_DEPTH = tde_pkg::LOOKAHEAD_DEPTH_DEF,
    parameter int TOP_CODE_INDEX  = tde_pkg::TOP_CODE_INDEX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_value
    input  logic        s_tlast,   // end_of_block
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] code_byte
    output logic        m_tlast    // final_byte
);
    import tde_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    tde_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    tde_datapath #(
        .MAX_ZERO_RUN    (MAX_ZERO_RUN),
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
        .TOP_CODE_INDEX  (TOP_CODE_INDEX)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hdl/tde_checker.sv =====
// Port-level checks for trace_delta_codebook_encoder, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tde_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `TDE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid)
    `TDE_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    `TDE_ASSERT(a_one_request, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `TDE_ASSERT_RST(a_reset_quiet, aclk, !aresetn |=> !m_tvalid)

endmodule

bind trace_delta_codebook_encoder tde_checker u_tde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/tb_trace_delta_codebook_encoder.sv =====
// Testbench for trace_delta_codebook_encoder: drives sample requests, predicts the
// byte stream with a behavioral tokenizer and checks every output byte in order.
// Depends on tde_pkg and the encoder RTL.
module tb_trace_delta_codebook_encoder;
    timeunit 1ns;
    timeprecision 1ps;
    import tde_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
    } code_byte_t;

    class byte_scoreboard;
        code_byte_t  pending[$];
        int          errors;
        int          win[5];
        int unsigned fill;
        int unsigned zrun;
        code_byte_t  step_out[$];

        function void reset_state();
            fill = 0;
            zrun = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void push(logic [7:0] b);
            code_byte_t e;
            if (step_out.size() < RESULT_CAP) begin
                e.code = b;
                e.fin = 1'b0;
                step_out.push_back(e);
            end
        endfunction

        function void shift_out(int unsigned k);
            if (k >= fill) begin
                fill = 0;
            end else begin
                for (int i = 0; i < 5; i++)
                    if (i + k < 5) win[i] = win[i + k];
                fill -= k;
            end
        endfunction

        function int unsigned match_word();
            int unsigned len;
            bit ok;
            for (int w = TOP_CODE_INDEX_DEF; w > 1; w--) begin
                if (w >= BOOK_SIZE) continue;
                len = BOOK[w][0];
                if (len == 0 || len > fill) continue;
                ok = 1'b1;
                for (int k = 0; k < len; k++)
                    if (win[k] != BOOK[w][k + 1]) ok = 1'b0;
                if (ok) return w;
            end
            return 0;
        endfunction

        function void tokenize(bit last);
            int unsigned c;
            int unsigned w;
            int v;
            logic [15:0] raw;
            while (fill > 0) begin
                if (win[0] == 0) begin
                    c = 0;
                    while (c < fill && c < MAX_ZERO_RUN_DEF && win[c] == 0) c++;
                    if (c < fill || c >= MAX_ZERO_RUN_DEF || last) begin
                        push(8'(c & 'h7f));
                        shift_out(c);
                    end else begin
                        zrun = c;
                        fill = 0;
                        break;
                    end
                end else begin
                    v = win[0];
                    if (fill < LOOKAHEAD_DEPTH_DEF && !last) break;
                    w = match_word();
                    if (w != 0) begin
                        push(8'h80 | 8'(w & 'h7f));
                        shift_out(BOOK[w][0]);
                    end else if (v < 128 && v > -129) begin
                        push(BYTE_SMALL);
                        push(8'(v + 128));
                        shift_out(1);
                    end else begin
                        raw = 16'(v);
                        push(BYTE_BIG);
                        push(raw[15:8]);
                        push(raw[7:0]);
                        shift_out(1);
                    end
                end
            end
        endfunction

        // note an accepted sample request and queue the bytes it produces
        function void note_sample(logic signed [15:0] s, bit last);
            int x;
            x = s;
            step_out.delete();
            if (zrun > 0 && x == 0) begin
                zrun++;
                if (zrun >= MAX_ZERO_RUN_DEF || last) begin
                    push(8'(zrun & 'h7f));
                    zrun = 0;
                end
            end else begin
                if (zrun > 0) begin
                    push(8'(zrun & 'h7f));
                    zrun = 0;
                end
                if (fill < LOOKAHEAD_DEPTH_DEF) begin
                    win[fill] = x;
                    fill++;
                end
                tokenize(last);
            end
            if (last && step_out.size() > 0) step_out[step_out.size() - 1].fin = 1'b1;
            foreach (step_out[i]) pending.push_back(step_out[i]);
        endfunction

        function void check_byte(logic [7:0] code, logic fin);
            code_byte_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %h/%b", $time, code, fin);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.code !== code) begin
                $display("%0t: code_byte mismatch, expected %h, actual %h", $time, e.code, code);
                errors++;
            end
            if (e.fin !== fin) begin
                $display("%0t: final_byte mismatch, expected %b, actual %b", $time, e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] sample_value
    logic        s_tlast;   // end_of_block
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] code_byte
    logic        m_tlast;   // final_byte

    byte_scoreboard sb;
    bit  quiet_phase;
    bit  hold_sink;
    int  cycle_count;
    localparam int CYCLE_LIMIT = 200000;

    trace_delta_codebook_encoder i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb_trace_delta_codebook_encoder failed");
                $finish;
            end
        end
    end

    // sink side: random stalls, one long hold-off on request
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    end

    task automatic send_sample(logic signed [15:0] v, bit last);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(v, last);
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'sd0;
            3, 4:    return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
            5:       return 16'($signed($urandom_range(0, 22)) - 11);
            6:       return 16'($signed($urandom_range(0, 255)) - 128);
            7:       return ($urandom_range(0, 1) != 0) ? 16'sd128 : -16'sd129;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int n;
        int len;
        sb = new();
        sb.reset_state();
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, literal boundaries, codebook words, word cut by block end
        send_sample(16'sh7fff, 0);
        send_sample(-16'sh8000, 0);
        send_sample(16'sd127, 0);
        send_sample(-16'sd128, 0);
        send_sample(16'sd128, 0);
        send_sample(-16'sd129, 0);
        send_sample(16'sd1, 0);
        send_sample(16'sd0, 0);
        send_sample(16'sd0, 0);
        send_sample(16'sd0, 0);
        send_sample(-16'sd1, 0);
        send_sample(16'sd11, 0);
        send_sample(16'sd1, 0);
        send_sample(16'sd0, 1);
        send_sample(16'sd0, 1);
        send_sample(16'sd1, 0);
        send_sample(-16'sd1, 0);
        send_sample(16'sd1, 0);
        send_sample(16'sd0, 0);
        send_sample(16'sd0, 1);
        send_sample(-16'sd1, 1);

        // full-length zero run, then force the sink to back up
        for (int i = 0; i < 130; i++) send_sample(16'sd0, i == 129);
        hold_sink = 1'b1;
        for (int i = 0; i < 20; i++) send_sample(16'($urandom), i == 19);

        n = 0;
        while (n < 160) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) send_sample(pick_value(), i == len - 1);
            n += len;
        end
        quiet_phase = 1'b1;
        while (n < 190) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) send_sample(pick_value(), i == len - 1);
            n += len;
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("tb_trace_delta_codebook_encoder passed");
        end else begin
            $display("tb_trace_delta_codebook_encoder failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tde_pkg.sv
hdl/tde_ctrl.sv
hdl/tde_datapath.sv
hdl/trace_delta_codebook_encoder.sv
hdl/tde_checker.sv
test/tb_trace_delta_codebook_encoder.sv
